// File: rtl/rchm_pkg.sv
// Shared types and constants for the RSSI coverage hole monitor.
package rchm_pkg;

    localparam int unsigned SAMPLE_W = 8;

    // Register map of the configuration channel.
    typedef enum logic [2:0] {
        REG_DATA_THR      = 3'd0,
        REG_MIN_FAILED    = 3'd1,
        REG_EXC_PERCENT   = 3'd2,
        REG_ROAM_ENABLE   = 3'd3,
        REG_ROAM_THR      = 3'd4,
        REG_INITIAL_POWER = 3'd5,
        REG_MAX_POWER     = 3'd6
    } rchm_reg_t;

    localparam logic signed [SAMPLE_W-1:0] DATA_THR_RESET = -8'sd80;

    // Control from the top level to the sample window.
    typedef struct packed {
        logic                       shift;   // Shift a new sample in.
        logic                       thr_wr;  // Load a new data threshold.
        logic signed [SAMPLE_W-1:0] thr;     // Threshold value to load.
    } rchm_win_ctl_t;

endpackage

// File: rtl/rchm_window.sv
// Sample window with per-entry failed marks and a running window sum.
module rchm_window #(
    parameter int unsigned  WINDOW_DEPTH = 31,
    localparam int unsigned SUM_W        = rchm_pkg::SAMPLE_W + $clog2(WINDOW_DEPTH + 1)
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  rchm_pkg::rchm_win_ctl_t                 ctl,
    input  logic signed [rchm_pkg::SAMPLE_W-1:0]    sample_in,
    output logic        [WINDOW_DEPTH-1:0]          below,
    output logic signed [SUM_W-1:0]                 sum
);
    import rchm_pkg::*;

    // A zero sample compared against the reset threshold.
    localparam logic ZERO_BELOW = (0 < DATA_THR_RESET);

    logic signed [SAMPLE_W-1:0] win_reg [WINDOW_DEPTH];
    logic        [WINDOW_DEPTH-1:0] below_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [SAMPLE_W-1:0] thr_reg;
    logic                       new_below;

    assign new_below = (sample_in < thr_reg);

    // Index 0 holds the oldest sample; new samples enter at the top.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                win_reg[i] <= '0;
            end
            below_reg <= {WINDOW_DEPTH{ZERO_BELOW}};
            sum_reg   <= '0;
            thr_reg   <= DATA_THR_RESET;
        end else if (ctl.thr_wr) begin
            thr_reg <= ctl.thr;
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                below_reg[i] <= (win_reg[i] < ctl.thr);
            end
        end else if (ctl.shift) begin
            for (int i = 0; i + 1 < WINDOW_DEPTH; i++) begin
                win_reg[i]   <= win_reg[i+1];
                below_reg[i] <= below_reg[i+1];
            end
            win_reg[WINDOW_DEPTH-1]   <= sample_in;
            below_reg[WINDOW_DEPTH-1] <= new_below;
            sum_reg <= sum_reg + SUM_W'(sample_in) - SUM_W'(win_reg[0]);
        end
    end

    assign below = below_reg;
    assign sum   = sum_reg;

endmodule

// File: rtl/rssi_coverage_hole_monitor_core.sv
// Top level of the RSSI coverage hole monitor: handshakes, decision logic and result register.
//
// The monitor takes one signed RSSI sample per input word, keeps the last WINDOW_DEPTH samples
// (zeros after reset) and returns one result word per sample with the count of window samples
// below the data threshold, the sticky pre-alarm and coverage hole flags, the one-time
// mitigation flag, the transmit power after that sample, the window average (truncated toward
// zero) and the roaming disassociation request. An accepted sample is shifted into the window,
// which updates its failed marks and a running sum; when the result slot is free, the count,
// flags, power and average are worked out and loaded into the result register. Throughput is
// one word per clock while the result side does not stall. The input side keeps accepting
// while a result waits, until one further sample is held in the window stage. Configuration
// writes are accepted in every cycle and must only be issued while no word is in flight.
// Writing initial_power also loads the power level at once; writing the data threshold
// re-marks every stored sample against the new value. There is no clearing pass after reset.
module rssi_coverage_hole_monitor_core #(
    parameter int unsigned WINDOW_DEPTH = 31
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rssi_sample
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    // [4:0] failed_count, [5] pre_alarm, [6] coverage_hole, [7] mitigation_done,
    // [13:8] transmit power, [21:14] average_rssi, [22] disassociate, [23] zero
    output logic [23:0] m_tdata,
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import rchm_pkg::*;

    localparam int unsigned SUM_W    = SAMPLE_W + $clog2(WINDOW_DEPTH + 1);
    localparam int unsigned CNT_W    = $clog2(WINDOW_DEPTH + 1);
    localparam int unsigned CMP_W    = (CNT_W > 5) ? CNT_W : 5;
    localparam int unsigned PM_W     = CNT_W + 7;
    // Exact division of the window sum magnitude by the depth through a reciprocal.
    localparam int unsigned MAG_W    = SUM_W;
    localparam int unsigned RECIP_W  = MAG_W + 1;
    localparam int unsigned PROD_W   = MAG_W + RECIP_W;
    localparam int unsigned DIV_SH   = MAG_W + $clog2(WINDOW_DEPTH);
    localparam longint unsigned RECIP =
        ((64'd1 << DIV_SH) + WINDOW_DEPTH - 1) / WINDOW_DEPTH;

    localparam int unsigned HOLE_MIN_COUNT = 3;
    localparam int unsigned PCT_SCALE      = 100;
    localparam logic [5:0]  POWER_CEILING  = 6'd63;
    localparam logic [5:0]  INIT_POWER_RST = 6'd15;
    localparam logic [5:0]  MAX_POWER_RST  = 6'd30;
    localparam logic [4:0]  MIN_FAIL_RST   = 5'd3;
    localparam logic [6:0]  EXC_PCT_RST    = 7'd25;
    localparam logic signed [7:0] ROAM_THR_RST = -8'sd80;

    // Configuration registers.
    logic [4:0]        min_fail_reg;
    logic [6:0]        exc_pct_reg;
    logic              roam_en_reg;
    logic signed [7:0] roam_thr_reg;
    logic [5:0]        max_power_reg;

    // Monitor state.
    logic       pre_reg;
    logic       hole_reg;
    logic       mit_reg;
    logic [5:0] power_reg;

    // Pipeline control and result register.
    logic        pend_reg;
    logic        m_tvalid_reg;
    logic [4:0]  out_cnt_reg;
    logic        out_pre_reg;
    logic        out_hole_reg;
    logic        out_mit_reg;
    logic [5:0]  out_power_reg;
    logic [7:0]  out_avg_reg;
    logic        out_dis_reg;

    logic s_acc;
    logic cfg_acc;
    logic fire;

    rchm_win_ctl_t              win_ctl;
    logic [WINDOW_DEPTH-1:0]    below;
    logic signed [SUM_W-1:0]    sum;

    // The result stage fires when a sample sits in the window and the result slot is free.
    assign fire     = pend_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !pend_reg || fire;
    assign s_acc    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_acc  = cfg_valid && cfg_ready;

    assign win_ctl.shift  = s_acc;
    assign win_ctl.thr_wr = cfg_acc && (cfg_index == REG_DATA_THR);
    assign win_ctl.thr    = signed'(cfg_data);

    rchm_window #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (win_ctl),
        .sample_in (signed'(s_tdata)),
        .below     (below),
        .sum       (sum)
    );

    function automatic logic [5:0] sat_inc(input logic [5:0] p);
        logic [5:0] r;
        r = (p < POWER_CEILING) ? p + 6'd1 : p;
        return r;
    endfunction

    // Failed count over the marked window entries.
    logic [CNT_W-1:0] count;
    always_comb begin
        count = '0;
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
            count = count + CNT_W'(below[i]);
        end
    end

    // Flag and power decision for the sample in the window stage.
    logic       pre_next;
    logic       hole_next;
    logic       mit_next;
    logic [5:0] power_mid;
    logic [5:0] power_next;
    logic       half_full;
    logic       mit_cond;

    always_comb begin
        half_full = ((CNT_W + 1)'(count) << 1) >= (CNT_W + 1)'(WINDOW_DEPTH);
        pre_next  = pre_reg || half_full;
        hole_next = hole_reg || (half_full && (CMP_W'(count) >= CMP_W'(HOLE_MIN_COUNT)));
        mit_cond  = hole_next && !mit_reg
                    && (CMP_W'(count) >= CMP_W'(min_fail_reg))
                    && (PM_W'(count) * PM_W'(PCT_SCALE)
                        >= PM_W'(exc_pct_reg) * PM_W'(WINDOW_DEPTH));
        mit_next  = mit_reg || mit_cond;
        power_mid = mit_cond ? sat_inc(power_reg) : power_reg;
        power_next = (hole_next && (power_mid < max_power_reg)) ? sat_inc(power_mid)
                                                                : power_mid;
    end

    // Window average, truncated toward zero, and the roaming check.
    logic              sum_neg;
    logic [MAG_W-1:0]  sum_mag;
    logic [PROD_W-1:0] quot_prod;
    logic [7:0]        quot;
    logic signed [7:0] avg;
    logic              dis;

    always_comb begin
        sum_neg   = sum[SUM_W-1];
        sum_mag   = sum_neg ? MAG_W'(-sum) : MAG_W'(sum);
        quot_prod = PROD_W'(sum_mag) * PROD_W'(RECIP);
        quot      = quot_prod[DIV_SH +: 8];
        avg       = sum_neg ? signed'(-quot) : signed'(quot);
        dis       = roam_en_reg && (avg < roam_thr_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_fail_reg  <= MIN_FAIL_RST;
            exc_pct_reg   <= EXC_PCT_RST;
            roam_en_reg   <= 1'b1;
            roam_thr_reg  <= ROAM_THR_RST;
            max_power_reg <= MAX_POWER_RST;
            pre_reg       <= 1'b0;
            hole_reg      <= 1'b0;
            mit_reg       <= 1'b0;
            power_reg     <= INIT_POWER_RST;
            pend_reg      <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_acc) begin
                case (cfg_index)
                    REG_MIN_FAILED:    min_fail_reg  <= cfg_data[4:0];
                    REG_EXC_PERCENT:   exc_pct_reg   <= cfg_data[6:0];
                    REG_ROAM_ENABLE:   roam_en_reg   <= cfg_data[0];
                    REG_ROAM_THR:      roam_thr_reg  <= signed'(cfg_data);
                    REG_INITIAL_POWER: power_reg     <= cfg_data[5:0];
                    REG_MAX_POWER:     max_power_reg <= cfg_data[5:0];
                    default: ;
                endcase
            end
            if (fire) begin
                pre_reg   <= pre_next;
                hole_reg  <= hole_next;
                mit_reg   <= mit_next;
                power_reg <= power_next;
            end
            if (s_acc) begin
                pend_reg <= 1'b1;
            end else if (fire) begin
                pend_reg <= 1'b0;
            end
            if (fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge aclk) begin
        if (fire) begin
            out_cnt_reg   <= 5'(count);
            out_pre_reg   <= pre_next;
            out_hole_reg  <= hole_next;
            out_mit_reg   <= mit_next;
            out_power_reg <= power_next;
            out_avg_reg   <= avg;
            out_dis_reg   <= dis;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_dis_reg, out_avg_reg, out_power_reg,
                       out_mit_reg, out_hole_reg, out_pre_reg, out_cnt_reg};

`ifndef SYNTHESIS
    // Mitigation is only ever applied inside a confirmed hole.
    a_mit_in_hole: assert property (@(posedge aclk) disable iff (!aresetn)
        mit_reg |-> hole_reg)
        else $error("mitigation flag set without coverage hole");

    // A confirmed hole always carries the pre-alarm.
    a_hole_pre: assert property (@(posedge aclk) disable iff (!aresetn)
        hole_reg |-> pre_reg)
        else $error("coverage hole flag set without pre-alarm");

    // A held sample with a stalled result slot blocks the input side.
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg && m_tvalid_reg && !m_tready) |-> !s_tready)
        else $error("input accepted while window stage is blocked");
`endif

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the RSSI coverage hole monitor core.
`timescale 1ns / 100ps

module testbench;
    import rchm_pkg::*;

    localparam int WINDOW_DEPTH   = 31;
    localparam int HOLE_MIN_COUNT = 3;
    localparam int CYCLE_LIMIT    = 200000;
    localparam logic [2:0] REG_UNMAPPED = 3'd7;

    // Result word as packed on m_tdata, highest field first.
    typedef struct packed {
        logic              spare;
        logic              disassociate;
        logic signed [7:0] average_rssi;
        logic [5:0]        txpwr;
        logic              mitigation_done;
        logic              coverage_hole;
        logic              pre_alarm;
        logic [4:0]        failed_count;
    } rssi_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;

    // Mirror of the monitor state and its registers.
    logic signed [7:0] rssi_window [WINDOW_DEPTH];
    logic              prealarm_q = 1'b0;
    logic              hole_q = 1'b0;
    logic              mitigated_q = 1'b0;
    logic [5:0]        power_q = 6'd15;
    logic signed [7:0] data_thr = DATA_THR_RESET;
    logic [4:0]        min_failed = 5'd3;
    logic [6:0]        exc_pct = 7'd25;
    logic              roam_en = 1'b1;
    logic signed [7:0] roam_thr = -8'sd80;
    logic [5:0]        max_power = 6'd30;

    logic [7:0]   pending_samples [$];
    rssi_result_t expected_words [$];
    int           mismatches = 0;
    int           cycle_count = 0;
    int           send_gap = 0;
    int           recv_gap = 0;
    bit           quiet = 1'b0;

    rssi_coverage_hole_monitor_core #(.WINDOW_DEPTH(WINDOW_DEPTH)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic logic [5:0] power_raise(logic [5:0] level);
        return (level == 6'd63) ? level : level + 6'd1;
    endfunction

    // Shifts one sample into the mirrored window and returns the word the block should emit.
    function automatic rssi_result_t advance_window(logic signed [7:0] sample);
        rssi_result_t r;
        int failed = 0;
        int total = 0;
        int mean;
        for (int i = 0; i < WINDOW_DEPTH - 1; i++) rssi_window[i] = rssi_window[i + 1];
        rssi_window[WINDOW_DEPTH - 1] = sample;
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
            if (rssi_window[i] < data_thr) failed++;
            total += int'(rssi_window[i]);
        end
        if (failed * 2 >= WINDOW_DEPTH) begin
            prealarm_q = 1'b1;
            if (failed >= HOLE_MIN_COUNT) hole_q = 1'b1;
        end
        if (hole_q && !mitigated_q && failed >= int'(min_failed) &&
            failed * 100 >= int'(exc_pct) * WINDOW_DEPTH) begin
            power_q = power_raise(power_q);
            mitigated_q = 1'b1;
        end
        if (hole_q && power_q < max_power) power_q = power_raise(power_q);
        mean = total / WINDOW_DEPTH;
        r = '0;
        r.failed_count    = failed[4:0];
        r.pre_alarm       = prealarm_q;
        r.coverage_hole   = hole_q;
        r.mitigation_done = mitigated_q;
        r.txpwr           = power_q;
        r.average_rssi    = mean[7:0];
        r.disassociate    = roam_en && (mean < int'(roam_thr));
        return r;
    endfunction

    // Mostly no pause, some short ones, a few long ones.
    function automatic int pick_gap();
        int r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Sender: one word per handshake, prediction made when the block takes it.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) expected_words.push_back(advance_window(s_tdata));
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_samples.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_samples.pop_front();
                    send_gap = pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Receiver: compares each result word with the oldest prediction.
    always @(posedge aclk) begin
        rssi_result_t got;
        rssi_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = rssi_result_t'(m_tdata);
                if (expected_words.size() == 0) begin
                    $display("%0t: result word with none expected, actual %h", $time, m_tdata);
                    mismatches++;
                end else begin
                    want = expected_words.pop_front();
                    check_field("failed_count", want.failed_count, got.failed_count);
                    check_field("pre_alarm", want.pre_alarm, got.pre_alarm);
                    check_field("coverage_hole", want.coverage_hole, got.coverage_hole);
                    check_field("mitigation_done", want.mitigation_done, got.mitigation_done);
                    check_field("txpwr", want.txpwr, got.txpwr);
                    check_field("average_rssi", want.average_rssi, got.average_rssi);
                    check_field("disassociate", want.disassociate, got.disassociate);
                    check_field("spare", want.spare, got.spare);
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) recv_gap = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_DATA_THR:      data_thr = value;
            REG_MIN_FAILED:    min_failed = value[4:0];
            REG_EXC_PERCENT:   exc_pct = value[6:0];
            REG_ROAM_ENABLE:   roam_en = value[0];
            REG_ROAM_THR:      roam_thr = value;
            REG_INITIAL_POWER: begin
                power_q    = value[5:0];
            end
            REG_MAX_POWER:     max_power = value[5:0];
            default: ;
        endcase
    endtask

    // Random register setting, weighted toward the ends of each range.
    task automatic shuffle_registers();
        int lo;
        int hi;
        int r;
        int v;
        for (int i = 0; i <= int'(REG_MAX_POWER); i++) begin
            if ($urandom_range(0, 9) < 7) begin
                case (3'(i))
                    REG_DATA_THR, REG_ROAM_THR: begin lo = -128; hi = 127; end
                    REG_MIN_FAILED:             begin lo = 0;    hi = 31;  end
                    REG_EXC_PERCENT:            begin lo = 0;    hi = 127; end
                    REG_ROAM_ENABLE:            begin lo = 0;    hi = 1;   end
                    default:                    begin lo = 0;    hi = 63;  end
                endcase
                r = $urandom_range(0, 8);
                v = (r < 3) ? lo : (r < 6) ? hi : lo + int'($urandom_range(0, hi - lo));
                write_reg(3'(i), v[7:0]);
            end
        end
    endtask

    // Sample drawn relative to the current data threshold.
    function automatic logic [7:0] draw_sample(input int mode);
        int t = int'(data_thr);
        int v;
        case (mode)
            1: v = (t == -128) ? -128 : int'($urandom_range(0, t + 127)) - 128;
            2: v = t + int'($urandom_range(0, 127 - t));
            3: begin
                v = t - 2 + int'($urandom_range(0, 4));
                if (v < -128) v = -128;
                if (v > 127) v = 127;
            end
            default: v = int'($urandom_range(0, 255));
        endcase
        return v[7:0];
    endfunction

    // Runs of failing, passing, borderline or arbitrary samples.
    task automatic queue_bursts(input int count, input int low_pct);
        int mode;
        int len;
        while (count > 0) begin
            mode = ($urandom_range(0, 99) < low_pct) ? 1 : $urandom_range(0, 2) * 1;
            if (mode == 1) mode = 3;
            if ($urandom_range(0, 99) < low_pct) mode = 1;
            len = $urandom_range(1, 40);
            if (len > count) len = count;
            repeat (len) pending_samples.push_back(draw_sample(mode));
            count -= len;
        end
    endtask

    // Holds off until the block has nothing in flight; checked between clock edges so that
    // every update of the sender and receiver has settled.
    task automatic wait_drained();
        while (pending_samples.size() > 0 || s_tvalid || expected_words.size() > 0)
            @(negedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        logic [7:0] corner_samples [12];
        corner_samples = '{8'h80, 8'h7f, 8'h00, 8'hff, 8'h01, 8'hb0,
                           8'haf, 8'hb1, 8'h40, 8'hc0, 8'h55, 8'haa};
        foreach (rssi_window[i]) rssi_window[i] = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings with the field extremes and values around the default threshold.
        foreach (corner_samples[i]) pending_samples.push_back(corner_samples[i]);
        wait_drained();

        // Nothing can fail; every average is below the roaming threshold.
        write_reg(REG_DATA_THR, 8'h80);
        write_reg(REG_ROAM_THR, 8'h7f);
        queue_bursts(40, 0);
        wait_drained();

        // Roaming off and the lowest roaming threshold, with no idling at all.
        quiet = 1'b1;
        write_reg(REG_ROAM_ENABLE, 8'h00);
        write_reg(REG_ROAM_THR, 8'h80);
        queue_bursts(30, 0);
        wait_drained();
        quiet = 1'b0;

        // Long runs of very low samples push the average across the roaming threshold.
        write_reg(REG_ROAM_ENABLE, 8'h01);
        write_reg(REG_ROAM_THR, 8'hc4);
        write_reg(REG_UNMAPPED, 8'h5a);
        queue_bursts(60, 70);
        wait_drained();

        // Hole with a percentage above 100: power only climbs to its maximum.
        write_reg(REG_DATA_THR, 8'h7f);
        write_reg(REG_MIN_FAILED, 8'h00);
        write_reg(REG_EXC_PERCENT, 8'h7f);
        write_reg(REG_INITIAL_POWER, 8'h05);
        write_reg(REG_MAX_POWER, 8'h14);
        queue_bursts(40, 60);
        wait_drained();

        // Mitigation needs a full window of failures and lands on the power ceiling.
        write_reg(REG_DATA_THR, 8'h00);
        write_reg(REG_MIN_FAILED, 8'h1f);
        write_reg(REG_EXC_PERCENT, 8'h00);
        write_reg(REG_INITIAL_POWER, 8'h3f);
        write_reg(REG_MAX_POWER, 8'h3f);
        queue_bursts(60, 80);
        wait_drained();

        // Zero power and maximum, full percentage.
        write_reg(REG_EXC_PERCENT, 8'h64);
        write_reg(REG_INITIAL_POWER, 8'h00);
        write_reg(REG_MAX_POWER, 8'h00);
        queue_bursts(40, 50);
        wait_drained();

        repeat (4) begin
            shuffle_registers();
            queue_bursts(45, $urandom_range(10, 90));
            wait_drained();
        end

        repeat (8) @(posedge aclk);
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: rssi_coverage_hole_monitor_core.f
rtl/rchm_pkg.sv
rtl/rchm_window.sv
rtl/rssi_coverage_hole_monitor_core.sv
verif/testbench.sv
